// ===== rtl/core/lrt_pkg.sv =====
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared types and codes for the LRU replacement tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

    localparam int FRAME_W    = 6;
    localparam int FRAME_SPAN = 2 ** FRAME_W;
    localparam int CNT_W      = 7;

    typedef enum logic [1:0] {
        ACT_TOUCH  = 2'd0,
        ACT_VICTIM = 2'd1,
        ACT_ERASE  = 2'd2
    } action_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [FRAME_W-1:0] frame_id;
    } cmd_t;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] victim_frame;
        logic [CNT_W-1:0]   entries;
    } rsp_t;

endpackage

// ===== rtl/core/lru_replacement_tracker_top.sv =====
// ----------------------------------------------------------------------------
// lru_replacement_tracker_top
// LRU order of frame numbers kept as a doubly linked list in two link RAMs.
//
//   channel  dir  handshake             word
//   cmd      in   cmd_valid/cmd_stall   action, frame_id
//   rsp      out  rsp_valid/rsp_stall   ok, victim_frame, entries
//
// A word is accepted with the link RAM read, then comes the result hand-off
// alongside an optional unlink write, then an optional relink write; set by
// the single write port of each link RAM. No word is accepted meanwhile.
// Reset clears presence bits, count, head and tail at once; links need none.
// A stalled result is held; one further word is accepted behind it.
// ----------------------------------------------------------------------------
module lru_replacement_tracker_top #(
    parameter int NUM_FRAMES = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  lrt_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output lrt_pkg::rsp_t rsp
);

    import lrt_pkg::*;

    localparam int IW = $clog2(NUM_FRAMES);

    logic          res_load;
    rsp_t          res;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] newer_rdata;
    logic [IW-1:0] older_rdata;
    logic          newer_we;
    logic [IW-1:0] newer_waddr;
    logic [IW-1:0] newer_wdata;
    logic          older_we;
    logic [IW-1:0] older_waddr;
    logic [IW-1:0] older_wdata;

    logic          pend_reg,      pend_next;
    rsp_t          pend_word_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg;
    logic          move;

    lrt_ctrl #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .hold        (pend_reg),
        .res_load    (res_load),
        .res         (res),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .newer_rdata (newer_rdata),
        .older_rdata (older_rdata),
        .newer_we    (newer_we),
        .newer_waddr (newer_waddr),
        .newer_wdata (newer_wdata),
        .older_we    (older_we),
        .older_waddr (older_waddr),
        .older_wdata (older_wdata)
    );

    lrt_link_ram #(
        .DEPTH(NUM_FRAMES)
    ) u_newer (
        .clk   (clk),
        .we    (newer_we),
        .waddr (newer_waddr),
        .wdata (newer_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (newer_rdata)
    );

    lrt_link_ram #(
        .DEPTH(NUM_FRAMES)
    ) u_older (
        .clk   (clk),
        .we    (older_we),
        .waddr (older_waddr),
        .wdata (older_wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (older_rdata)
    );

    assign move = pend_reg && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        if (res_load)
        begin
            pend_next = 1'b1;
        end
        else if (move)
        begin
            pend_next = 1'b0;
        end
        if (move)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            pend_word_reg <= res;
        end
        if (move)
        begin
            rsp_reg <= pend_word_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== rtl/core/lrt_link_ram.sv =====
// ----------------------------------------------------------------------------
// lrt_link_ram
// One-write, one-read synchronous RAM holding one link per frame.
// ----------------------------------------------------------------------------
module lrt_link_ram #(
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// lrt_ctrl
// Sequencer: presence bits, count, head and tail; unlink and relink steps
// against the newer and older link RAMs.
// ----------------------------------------------------------------------------
module lrt_ctrl #(
    parameter int NUM_FRAMES = 64,
    localparam int IW = $clog2(NUM_FRAMES)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  lrt_pkg::cmd_t cmd,
    input  logic          hold,
    output logic          res_load,
    output lrt_pkg::rsp_t res,
    output logic          rd_en,
    output logic [IW-1:0] rd_addr,
    input  logic [IW-1:0] newer_rdata,
    input  logic [IW-1:0] older_rdata,
    output logic          newer_we,
    output logic [IW-1:0] newer_waddr,
    output logic [IW-1:0] newer_wdata,
    output logic          older_we,
    output logic [IW-1:0] older_waddr,
    output logic [IW-1:0] older_wdata
);

    import lrt_pkg::*;

    localparam int PN = (NUM_FRAMES < FRAME_SPAN) ? NUM_FRAMES : FRAME_SPAN;
    localparam int PW = $clog2(PN);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UNLINK,
        ST_LINK
    } state_t;

    state_t             state_reg,   state_next;
    logic [PN-1:0]      present_reg, present_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic [IW-1:0]      head_reg,    head_next;
    logic [IW-1:0]      tail_reg,    tail_next;
    logic [IW-1:0]      tgt_reg,     tgt_next;
    logic               relink_reg,  relink_next;

    logic               accept;
    logic [IW-1:0]      f_idx;
    logic [PW-1:0]      p_idx;
    logic [PW-1:0]      t_pidx;
    logic               in_range;
    logic               pres;
    logic               mid;
    logic               res_ok;
    logic [FRAME_W-1:0] res_victim;

    assign cmd_stall = !((state_reg == ST_IDLE) && !hold);
    assign accept    = cmd_valid && !cmd_stall;
    assign f_idx     = IW'(cmd.frame_id);
    assign p_idx     = PW'(cmd.frame_id);
    assign t_pidx    = PW'(tail_reg);
    assign in_range  = 32'(cmd.frame_id) < NUM_FRAMES;
    assign pres      = in_range && present_reg[p_idx];

    assign rd_en   = accept;
    assign rd_addr = (cmd.action == ACT_VICTIM) ? tail_reg : f_idx;

    always_comb
    begin
        state_next   = state_reg;
        present_next = present_reg;
        count_next   = count_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        tgt_next     = tgt_reg;
        relink_next  = relink_reg;
        res_ok       = 1'b0;
        res_victim   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (cmd.action == ACT_TOUCH)
                    begin
                        if (in_range)
                        begin
                            res_ok      = 1'b1;
                            tgt_next    = f_idx;
                            relink_next = 1'b1;
                            if (!pres)
                            begin
                                present_next[p_idx] = 1'b1;
                                count_next          = count_reg + CNT_W'(1);
                                if (count_reg == '0)
                                begin
                                    head_next = f_idx;
                                    tail_next = f_idx;
                                end
                                else
                                begin
                                    state_next = ST_LINK;
                                end
                            end
                            else if (f_idx != head_reg)
                            begin
                                state_next = ST_UNLINK;
                            end
                        end
                    end
                    else if (cmd.action == ACT_VICTIM)
                    begin
                        if (count_reg != '0)
                        begin
                            res_ok               = 1'b1;
                            res_victim           = FRAME_W'(tail_reg);
                            present_next[t_pidx] = 1'b0;
                            count_next           = count_reg - CNT_W'(1);
                            tgt_next             = tail_reg;
                            relink_next          = 1'b0;
                            if (count_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                state_next = ST_UNLINK;
                            end
                        end
                    end
                    else if (cmd.action == ACT_ERASE)
                    begin
                        if (pres)
                        begin
                            res_ok              = 1'b1;
                            present_next[p_idx] = 1'b0;
                            count_next          = count_reg - CNT_W'(1);
                            tgt_next            = f_idx;
                            relink_next         = 1'b0;
                            if (count_reg == CNT_W'(1))
                            begin
                                head_next = '0;
                                tail_next = '0;
                            end
                            else
                            begin
                                state_next = ST_UNLINK;
                            end
                        end
                    end
                    else
                    begin
                        res_ok = 1'b0;
                    end
                end
            end
            ST_UNLINK:
            begin
                priority if (tgt_reg == head_reg)
                begin
                    head_next = older_rdata;
                end
                else if (tgt_reg == tail_reg)
                begin
                    tail_next = newer_rdata;
                end
                else
                begin
                    head_next = head_reg;
                end
                state_next = relink_reg ? ST_LINK : ST_IDLE;
            end
            ST_LINK:
            begin
                head_next  = tgt_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // middle node: splice its neighbours together
    assign mid = (tgt_reg != head_reg) && (tgt_reg != tail_reg);

    always_comb
    begin
        newer_we    = ((state_reg == ST_UNLINK) && mid) || (state_reg == ST_LINK);
        older_we    = newer_we;
        if (state_reg == ST_UNLINK)
        begin
            newer_waddr = older_rdata;
            newer_wdata = newer_rdata;
            older_waddr = newer_rdata;
            older_wdata = older_rdata;
        end
        else
        begin
            newer_waddr = head_reg;
            newer_wdata = tgt_reg;
            older_waddr = tgt_reg;
            older_wdata = head_reg;
        end
    end

    assign res_load         = accept;
    assign res.ok           = res_ok;
    assign res.victim_frame = res_victim;
    assign res.entries      = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            present_reg <= '0;
            count_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            tgt_reg     <= '0;
            relink_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            tgt_reg     <= tgt_next;
            relink_reg  <= relink_next;
        end
    end

endmodule

// ===== rtl/core/lrt_checker.sv =====
// ----------------------------------------------------------------------------
// lrt_checker
// Port-level checks on the LRU replacement tracker, bound to the top level.
// ----------------------------------------------------------------------------
module lrt_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_stall,
    input lrt_pkg::cmd_t cmd,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input lrt_pkg::rsp_t rsp
);

    import lrt_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second word accepted while first still in flight");

    a_entries_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entries <= CNT_W'(FRAME_SPAN))
        else $error("entry count beyond frame span");

    a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.ok |-> rsp.victim_frame == '0)
        else $error("victim frame set on a failed word");

endmodule

bind lru_replacement_tracker_top lrt_checker u_lrt_checker (.*);
